[hdl/ffbha_pkg.sv]
// ----------------------------------------------------------------------------
// ffbha_pkg
// shared constants and codes of the first-fit block heap allocator
// ----------------------------------------------------------------------------
package ffbha_pkg;

    localparam int BLOCK_ENTRIES_DEF = 256;
    localparam int ADDR_BITS_DEF     = 48;
    localparam int SIZE_BITS_DEF     = 32;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_ALIGNED = 2'd1;
    localparam logic [1:0] REQ_FREE    = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_HEAP_BASE   = 8'd0;
    localparam logic [7:0] CFG_HEAP_LENGTH = 8'd1;

endpackage

[hdl/ffbha_ram.sv]
// ----------------------------------------------------------------------------
// ffbha_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ffbha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/first_fit_block_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_heap_allocator
// first-fit heap allocator over a table of block descriptors held in one ram
// ----------------------------------------------------------------------------
// The descriptor table sits in one ram with a registered read; each request is
// a sequence of read, check and write steps over it, one request at a time.
// An allocation scans the table entry by entry and then writes the descriptors;
// an aligned allocation adds up to two passes of a bit-serial modulo unit over
// max(ADDR_BITS,32) bits. A free walks the list and then coalesces neighbours.
// Every allocation gives one result beat; a free gives none. A register write
// reloads the table at once through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_block_heap_allocator
    import ffbha_pkg::*;
#(
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF,
    parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // req_size[31:0], req_align[48:32], free_addr[96:49]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // alloc_addr[47:0]
    output logic         m_tuser,   // alloc_ok[0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam int IDX_W  = $clog2(BLOCK_ENTRIES);
    localparam int NEED_W = (SIZE_BITS > 33) ? SIZE_BITS : 33;
    localparam int MOD_W  = (ADDR_BITS > 32) ? ADDR_BITS : 32;
    localparam int MCNT_W = $clog2(MOD_W);

    typedef struct packed {
        logic                 in_use;
        logic                 is_free;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
        logic [IDX_W-1:0]     nxt;
        logic                 has_next;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_MOD_SZ  = 17'h00002,
        S_SCAN_RD = 17'h00004,
        S_SCAN_CK = 17'h00008,
        S_FIT     = 17'h00010,
        S_MOD_ST  = 17'h00020,
        S_WR_D    = 17'h00040,
        S_WR_U    = 17'h00080,
        S_WR_F    = 17'h00100,
        S_RESULT  = 17'h00200,
        S_FW_RD   = 17'h00400,
        S_FW_CK   = 17'h00800,
        S_CO_RD   = 17'h01000,
        S_CO_CK   = 17'h02000,
        S_CO_NRD  = 17'h04000,
        S_CO_NCK  = 17'h08000,
        S_CO_WR   = 17'h10000
    } state_t;

    state_t               state_reg;
    logic [1:0]           op_reg;
    logic [31:0]          size_reg;
    logic [16:0]          align_reg;
    logic [ADDR_BITS-1:0] faddr_reg;
    logic [NEED_W-1:0]    need_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     nidx_reg;
    logic                 got_reg;
    logic [IDX_W-1:0]     didx_reg;
    logic [1:0]           nsp_reg;
    logic [IDX_W-1:0]     sp0_reg;
    logic [IDX_W-1:0]     sp1_reg;
    desc_t                d_reg;
    desc_t                u_reg;
    desc_t                f_reg;
    logic                 exact_reg;
    logic                 fpend_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [17:0]          rem_reg;
    logic [MOD_W-1:0]     mx_reg;
    logic [MCNT_W-1:0]    mcnt_reg;
    logic [47:0]          base_reg;
    logic [31:0]          len_reg;
    logic                 mvalid_reg;
    logic [47:0]          mdata_reg;
    logic                 mok_reg;
    logic                 mok_out_reg;
    logic                 valid_reg [BLOCK_ENTRIES];
    logic [IDX_W-1:0]     rq_addr_reg;
    logic                 rq_vld_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    desc_t             wdata;
    logic [IDX_W-1:0]  raddr;
    logic [DESC_W-1:0] ram_rdata;
    desc_t             e;
    desc_t             reset0;
    desc_t             sd;
    desc_t             su;
    logic              cfg_hit;
    logic              in_beat;
    logic [17:0]       rem_sh;
    logic [17:0]       rem_nx;
    logic              mod_last;
    logic              last_step;
    logic [1:0]        want;
    logic              take_donor;
    logic              take_spare;
    logic              got_nx;
    logic [1:0]        nsp_nx;
    logic              merge;
    logic [16:0]       corr;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = mok_out_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && ((cfg_index == CFG_HEAP_BASE) ||
                                     (cfg_index == CFG_HEAP_LENGTH));

    ffbha_ram #(
        .WIDTH (DESC_W),
        .DEPTH (BLOCK_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // an entry never written since the last reload reads as its reset value
    always_comb
    begin
        reset0          = '0;
        reset0.in_use   = 1'b1;
        reset0.is_free  = 1'b1;
        reset0.start    = ADDR_BITS'(base_reg);
        reset0.size     = SIZE_BITS'(len_reg);
        if (rq_vld_reg)
        begin
            e = desc_t'(ram_rdata);
        end
        else if (rq_addr_reg == '0)
        begin
            e = reset0;
        end
        else
        begin
            e = '0;
        end
    end

    assign raddr     = (state_reg == S_CO_NRD) ? nidx_reg : idx_reg;
    assign last_step = (cnt_reg == IDX_W'(BLOCK_ENTRIES - 1));

    // bit-serial remainder by the alignment
    assign rem_sh   = {rem_reg[16:0], mx_reg[MOD_W-1]};
    assign rem_nx   = (rem_sh >= 18'(align_reg)) ? rem_sh - 18'(align_reg) : rem_sh;
    assign mod_last = (mcnt_reg == MCNT_W'(MOD_W - 1));
    assign corr     = align_reg - rem_nx[16:0];

    // scan decision for the current entry
    assign want       = (op_reg == REQ_ALLOC) ? 2'd1 : 2'd2;
    assign take_donor = !got_reg && e.in_use && e.is_free &&
                        (NEED_W'(e.size) >= need_reg);
    assign take_spare = !take_donor && !e.in_use && (nsp_reg < want);
    assign got_nx     = got_reg || take_donor;
    assign nsp_nx     = take_spare ? nsp_reg + 2'd1 : nsp_reg;

    // tail split of the donor
    always_comb
    begin
        sd          = d_reg;
        sd.size     = d_reg.size - SIZE_BITS'(need_reg);
        sd.nxt      = sp0_reg;
        sd.has_next = 1'b1;
        su          = d_reg;
        su.in_use   = 1'b1;
        su.is_free  = 1'b0;
        su.size     = SIZE_BITS'(need_reg);
        su.start    = d_reg.start + ADDR_BITS'(sd.size);
    end

    assign merge = d_reg.is_free && e.is_free && (nidx_reg != idx_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = d_reg;
        case (state_reg)
            S_WR_D:
            begin
                we    = 1'b1;
                waddr = didx_reg;
                wdata = d_reg;
            end
            S_WR_U:
            begin
                we    = 1'b1;
                waddr = sp0_reg;
                wdata = u_reg;
            end
            S_WR_F:
            begin
                we    = 1'b1;
                waddr = sp1_reg;
                wdata = f_reg;
            end
            S_FW_CK:
            begin
                we            = (e.start == faddr_reg);
                waddr         = idx_reg;
                wdata         = e;
                wdata.is_free = 1'b1;
            end
            S_CO_NCK:
            begin
                we    = merge;
                waddr = nidx_reg;
                wdata = '0;
            end
            S_CO_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = d_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            base_reg   <= '0;
            len_reg    <= '0;
            for (int i = 0; i < BLOCK_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
            if (cfg_hit)
            begin
                if (cfg_index == CFG_HEAP_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else
                begin
                    len_reg <= cfg_data[31:0];
                end
                for (int i = 0; i < BLOCK_ENTRIES; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        case (s_tuser)
                            REQ_ALLOC:   state_reg <= S_SCAN_RD;
                            REQ_ALIGNED: state_reg <= (s_tdata[48:32] == '0) ?
                                                      S_RESULT : S_MOD_SZ;
                            REQ_FREE:    state_reg <= S_FW_RD;
                            default:     state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MOD_SZ:
                begin
                    if (mod_last)
                    begin
                        state_reg <= (rem_nx != '0) ? S_RESULT : S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CK;
                end
                S_SCAN_CK:
                begin
                    if ((got_nx && nsp_nx == want) || idx_reg == IDX_W'(BLOCK_ENTRIES - 1))
                    begin
                        state_reg <= S_FIT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_FIT:
                begin
                    if (op_reg == REQ_ALLOC)
                    begin
                        if (got_reg && NEED_W'(d_reg.size) == need_reg)
                        begin
                            state_reg <= S_WR_D;
                        end
                        else if (!got_reg || nsp_reg == 2'd0)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_WR_D;
                        end
                    end
                    else
                    begin
                        state_reg <= (!got_reg || nsp_reg != 2'd2) ? S_RESULT : S_MOD_ST;
                    end
                end
                S_MOD_ST:
                begin
                    if (mod_last)
                    begin
                        state_reg <= S_WR_D;
                    end
                end
                S_WR_D:
                begin
                    state_reg <= exact_reg ? S_RESULT : S_WR_U;
                end
                S_WR_U:
                begin
                    state_reg <= fpend_reg ? S_WR_F : S_RESULT;
                end
                S_WR_F:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!mvalid_reg || m_tready)
                    begin
                        mvalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_FW_RD:
                begin
                    state_reg <= S_FW_CK;
                end
                S_FW_CK:
                begin
                    if (e.start == faddr_reg || !e.has_next || last_step)
                    begin
                        state_reg <= S_CO_RD;
                    end
                    else
                    begin
                        state_reg <= S_FW_RD;
                    end
                end
                S_CO_RD:
                begin
                    state_reg <= S_CO_CK;
                end
                S_CO_CK:
                begin
                    state_reg <= e.has_next ? S_CO_NRD : S_IDLE;
                end
                S_CO_NRD:
                begin
                    state_reg <= S_CO_NCK;
                end
                S_CO_NCK:
                begin
                    if (merge)
                    begin
                        state_reg <= S_CO_WR;
                    end
                    else
                    begin
                        state_reg <= last_step ? S_IDLE : S_CO_RD;
                    end
                end
                S_CO_WR:
                begin
                    state_reg <= (!d_reg.has_next || last_step) ? S_IDLE : S_CO_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rq_addr_reg <= raddr;
        rq_vld_reg  <= valid_reg[raddr];
        mcnt_reg    <= mcnt_reg + MCNT_W'(1);
        rem_reg     <= rem_nx;
        mx_reg      <= {mx_reg[MOD_W-2:0], 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                op_reg    <= s_tuser;
                size_reg  <= s_tdata[31:0];
                align_reg <= s_tdata[48:32];
                faddr_reg <= ADDR_BITS'(s_tdata[96:49]);
                need_reg  <= NEED_W'(s_tdata[31:0]);
                idx_reg   <= '0;
                cnt_reg   <= '0;
                got_reg   <= 1'b0;
                nsp_reg   <= '0;
                exact_reg <= 1'b0;
                fpend_reg <= 1'b0;
                addr_reg  <= '0;
                mok_reg   <= 1'b0;
                rem_reg   <= '0;
                mcnt_reg  <= '0;
                mx_reg    <= MOD_W'(s_tdata[31:0]);
            end
            S_MOD_SZ:
            begin
                need_reg <= NEED_W'(size_reg) + NEED_W'(align_reg);
            end
            S_SCAN_CK:
            begin
                got_reg <= got_nx;
                nsp_reg <= nsp_nx;
                idx_reg <= idx_reg + IDX_W'(1);
                if (take_donor)
                begin
                    didx_reg <= idx_reg;
                    d_reg    <= e;
                end
                if (take_spare)
                begin
                    if (nsp_reg == 2'd0)
                    begin
                        sp0_reg <= idx_reg;
                    end
                    else
                    begin
                        sp1_reg <= idx_reg;
                    end
                end
            end
            S_FIT:
            begin
                rem_reg  <= '0;
                mcnt_reg <= '0;
                mx_reg   <= MOD_W'(su.start);
                if (op_reg == REQ_ALLOC && got_reg && NEED_W'(d_reg.size) == need_reg)
                begin
                    exact_reg     <= 1'b1;
                    d_reg.is_free <= 1'b0;
                    d_reg.in_use  <= 1'b1;
                    addr_reg      <= d_reg.start;
                    mok_reg       <= 1'b1;
                end
                else
                begin
                    d_reg    <= sd;
                    u_reg    <= su;
                    addr_reg <= su.start;
                    mok_reg  <= got_reg && (nsp_reg >= want);
                end
            end
            S_MOD_ST:
            begin
                if (mod_last && rem_nx != '0)
                begin
                    fpend_reg        <= 1'b1;
                    f_reg.in_use     <= 1'b1;
                    f_reg.is_free    <= 1'b1;
                    f_reg.start      <= u_reg.start;
                    f_reg.size       <= SIZE_BITS'(corr);
                    f_reg.nxt        <= sp0_reg;
                    f_reg.has_next   <= 1'b1;
                    u_reg.start      <= u_reg.start + ADDR_BITS'(corr);
                    u_reg.size       <= u_reg.size - SIZE_BITS'(corr);
                    d_reg.nxt        <= sp1_reg;
                    addr_reg         <= u_reg.start + ADDR_BITS'(corr);
                end
            end
            S_RESULT:
            begin
                // the output beat holds until the previous one has left
                if (!mvalid_reg || m_tready)
                begin
                    mdata_reg   <= mok_reg ? 48'(addr_reg) : '0;
                    mok_out_reg <= mok_reg;
                end
            end
            S_FW_CK:
            begin
                if (e.start == faddr_reg || !e.has_next || last_step)
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    idx_reg <= e.nxt;
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
            end
            S_CO_CK:
            begin
                d_reg    <= e;
                nidx_reg <= e.nxt;
            end
            S_CO_NCK:
            begin
                if (merge)
                begin
                    d_reg.size     <= d_reg.size + e.size;
                    d_reg.nxt      <= e.nxt;
                    d_reg.has_next <= e.has_next;
                end
                else
                begin
                    idx_reg <= d_reg.nxt;
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
            end
            S_CO_WR:
            begin
                idx_reg <= d_reg.nxt;
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule
